[sv/sgr2irc_pkg.sv]
// shared types, byte codes and colour digit table for the sgr to irc converter
package sgr2irc_pkg;

    // parser mode of the front end
    typedef enum logic [1:0] {
        MODE_TEXT = 2'd0,
        MODE_ESC  = 2'd1,
        MODE_SEQ  = 2'd2
    } mode_t;

    // byte codes
    localparam logic [7:0] BYTE_ESC      = 8'h1B;
    localparam logic [7:0] BYTE_RESET    = 8'h0F;
    localparam logic [7:0] BYTE_COLOR    = 8'h03;
    localparam logic [7:0] BYTE_COMMA    = 8'h2C;
    localparam logic [7:0] BYTE_SEMI     = 8'h3B;
    localparam logic [7:0] BYTE_M        = 8'h6D;
    localparam logic [7:0] BYTE_LBRACKET = 8'h5B;
    localparam logic [7:0] BYTE_ZERO     = 8'h30;
    localparam logic [7:0] BYTE_NINE     = 8'h39;
    localparam logic [7:0] BYTE_ONE      = 8'h31;

    // colour index that means unset
    localparam logic [3:0] NO_COLOR = 4'hF;

    // output slots of one command: two plain bytes, then the colour burst
    localparam int SLOTS = 8;
    localparam logic [2:0] SLOT_PRE0  = 3'd0;
    localparam logic [2:0] SLOT_PRE1  = 3'd1;
    localparam logic [2:0] SLOT_CTRL  = 3'd2;
    localparam logic [2:0] SLOT_FG_HI = 3'd3;
    localparam logic [2:0] SLOT_FG_LO = 3'd4;
    localparam logic [2:0] SLOT_COMMA = 3'd5;
    localparam logic [2:0] SLOT_BG_HI = 3'd6;
    localparam logic [2:0] SLOT_BG_LO = 3'd7;

    // work handed from front to back for one input byte
    typedef struct packed {
        logic       pre0_v;
        logic [7:0] pre0;
        logic       pre1_v;
        logic [7:0] pre1;
        logic       col_v;
        logic [3:0] fg;
        logic [3:0] bg;
    } cmd_t;

    // irc colour digits: 01 04 03 07 02 06 11 15
    function automatic logic [7:0] color_digit(input logic [2:0] idx, input logic hi);
        logic [7:0] d;
        if (hi) begin
            d = (idx == 3'd6 || idx == 3'd7) ? BYTE_ONE : BYTE_ZERO;
        end else begin
            unique case (idx)
                3'd0:    d = 8'h31;
                3'd1:    d = 8'h34;
                3'd2:    d = 8'h33;
                3'd3:    d = 8'h37;
                3'd4:    d = 8'h32;
                3'd5:    d = 8'h36;
                3'd6:    d = 8'h31;
                default: d = 8'h35;
            endcase
        end
        return d;
    endfunction

endpackage

[sv/sgr2irc_front.sv]
// front end: parses input bytes, tracks colours and issues output commands
module sgr2irc_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    input  logic [7:0]          in_ch,
    input  logic                in_eot,
    output logic                in_ready,
    output logic                q_valid,
    input  logic                q_ready,
    output sgr2irc_pkg::cmd_t   q_cmd
);
    import sgr2irc_pkg::*;

    mode_t      mode_reg, mode_next, mode_step;
    logic [1:0] pchars_reg, pchars_next;
    logic [6:0] pvalue_reg, pvalue_next;
    logic       pended_reg, pended_next;
    logic [3:0] fg_reg, fg_next;
    logic [3:0] bg_reg, bg_next;

    logic       fire;
    logic       is_end;
    logic       is_digit;
    logic       is_zero;
    logic [6:0] pv_acc;
    logic [3:0] fg_dec, bg_dec;
    cmd_t       cmd;

    assign in_ready = q_ready;
    assign fire     = in_valid && q_ready;
    assign is_end   = (in_ch == BYTE_SEMI) || (in_ch == BYTE_M);
    assign is_digit = (in_ch >= BYTE_ZERO) && (in_ch <= BYTE_NINE);
    assign pv_acc   = 7'(pvalue_reg * 7'd10) + {3'b000, in_ch[3:0]};
    assign is_zero  = (pvalue_reg == 7'd0);

    // parameter decode
    always_comb begin
        fg_dec = fg_reg;
        bg_dec = bg_reg;
        if (pvalue_reg >= 7'd30 && pvalue_reg <= 7'd36) fg_dec = 4'(pvalue_reg - 7'd30);
        if (pvalue_reg == 7'd37 || pvalue_reg == 7'd39) fg_dec = NO_COLOR;
        if (pvalue_reg >= 7'd41 && pvalue_reg <= 7'd47) bg_dec = 4'(pvalue_reg - 7'd40);
        if (pvalue_reg == 7'd40 || pvalue_reg == 7'd49) bg_dec = NO_COLOR;
        if (is_zero) begin
            fg_dec = NO_COLOR;
            bg_dec = NO_COLOR;
        end
    end

    // next mode
    always_comb begin
        unique case (mode_reg)
            MODE_SEQ: mode_step = (in_ch == BYTE_M) ? MODE_TEXT : MODE_SEQ;
            MODE_ESC: begin
                if (in_ch == BYTE_LBRACKET) mode_step = MODE_SEQ;
                else mode_step = (in_ch == BYTE_ESC) ? MODE_ESC : MODE_TEXT;
            end
            default:  mode_step = (in_ch == BYTE_ESC) ? MODE_ESC : MODE_TEXT;
        endcase
        mode_next = in_eot ? MODE_TEXT : mode_step;
    end

    // parameter and colour state, command out
    always_comb begin
        pchars_next = pchars_reg;
        pvalue_next = pvalue_reg;
        pended_next = pended_reg;
        fg_next     = fg_reg;
        bg_next     = bg_reg;
        cmd         = '0;
        cmd.pre0    = in_ch;
        cmd.pre1    = in_ch;
        cmd.fg      = fg_dec;
        cmd.bg      = bg_dec;
        unique case (mode_reg)
            MODE_SEQ: begin
                if (is_end) begin
                    fg_next     = fg_dec;
                    bg_next     = bg_dec;
                    pchars_next = 2'd0;
                    pvalue_next = 7'd0;
                    pended_next = 1'b0;
                    cmd.pre0_v  = is_zero;
                    cmd.pre0    = BYTE_RESET;
                    cmd.col_v   = (in_ch == BYTE_M) &&
                                  ((fg_dec != NO_COLOR) || (bg_dec != NO_COLOR));
                end else if (pchars_reg < 2'd2) begin
                    pchars_next = pchars_reg + 2'd1;
                    if (!pended_reg) begin
                        if (is_digit) pvalue_next = pv_acc;
                        else pended_next = 1'b1;
                    end
                end
            end
            MODE_ESC: begin
                if (in_ch == BYTE_LBRACKET) begin
                    pchars_next = 2'd0;
                    pvalue_next = 7'd0;
                    pended_next = 1'b0;
                end else begin
                    cmd.pre0_v = 1'b1;
                    cmd.pre0   = BYTE_ESC;
                    cmd.pre1_v = (in_ch != BYTE_ESC);
                end
            end
            default: begin
                cmd.pre0_v = (in_ch != BYTE_ESC);
            end
        endcase
        // flush a pending escape at end of text
        if (in_eot && mode_step == MODE_ESC) begin
            if (cmd.pre0_v) begin
                cmd.pre1_v = 1'b1;
                cmd.pre1   = BYTE_ESC;
            end else begin
                cmd.pre0_v = 1'b1;
                cmd.pre0   = BYTE_ESC;
            end
        end
        if (in_eot) begin
            pchars_next = 2'd0;
            pvalue_next = 7'd0;
            pended_next = 1'b0;
            fg_next     = NO_COLOR;
            bg_next     = NO_COLOR;
        end
    end

    assign q_cmd   = cmd;
    assign q_valid = in_valid && (cmd.pre0_v || cmd.pre1_v || cmd.col_v);

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_TEXT;
            pchars_reg <= 2'd0;
            pvalue_reg <= 7'd0;
            pended_reg <= 1'b0;
            fg_reg     <= NO_COLOR;
            bg_reg     <= NO_COLOR;
        end else if (fire) begin
            mode_reg   <= mode_next;
            pchars_reg <= pchars_next;
            pvalue_reg <= pvalue_next;
            pended_reg <= pended_next;
            fg_reg     <= fg_next;
            bg_reg     <= bg_next;
        end
    end

endmodule

[sv/sgr2irc_queue.sv]
// small command fifo between the front end and the back end
module sgr2irc_queue #(
    parameter int DEPTH = 2
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  sgr2irc_pkg::cmd_t   in_cmd,
    output logic                out_valid,
    input  logic                out_ready,
    output sgr2irc_pkg::cmd_t   out_cmd
);
    import sgr2irc_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          mem_reg [DEPTH];
    logic [PW-1:0] wptr_reg, wptr_next;
    logic [PW-1:0] rptr_reg, rptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          push, pop;

    assign in_ready  = (count_reg != CW'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_cmd   = mem_reg[rptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // pointer and fill count update
    always_comb begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        if (push) wptr_next = (wptr_reg == PW'(DEPTH - 1)) ? '0 : wptr_reg + PW'(1);
        if (pop)  rptr_next = (rptr_reg == PW'(DEPTH - 1)) ? '0 : rptr_reg + PW'(1);
        unique case ({push, pop})
            2'b10:   count_next = count_reg + CW'(1);
            2'b01:   count_next = count_reg - CW'(1);
            default: count_next = count_reg;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) mem_reg[wptr_reg] <= in_cmd;
    end

endmodule

[sv/sgr2irc_back.sv]
// back end: expands one command into its output bytes, one per cycle while the output is ready
module sgr2irc_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    output logic                q_ready,
    input  sgr2irc_pkg::cmd_t   q_cmd,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          out_byte,
    output logic                out_last
);
    import sgr2irc_pkg::*;

    cmd_t             cmd_reg, cmd_next;
    logic [SLOTS-1:0] mask_reg, mask_next;
    logic [SLOTS-1:0] q_mask, rest;
    logic [2:0]       sel;
    logic             fire;

    // slots that a fresh command fills
    always_comb begin
        q_mask               = '0;
        q_mask[SLOT_PRE0]    = q_cmd.pre0_v;
        q_mask[SLOT_PRE1]    = q_cmd.pre1_v;
        q_mask[SLOT_CTRL]    = q_cmd.col_v;
        q_mask[SLOT_FG_HI]   = q_cmd.col_v && (q_cmd.fg != NO_COLOR);
        q_mask[SLOT_FG_LO]   = q_cmd.col_v && (q_cmd.fg != NO_COLOR);
        q_mask[SLOT_COMMA]   = q_cmd.col_v && (q_cmd.bg != NO_COLOR);
        q_mask[SLOT_BG_HI]   = q_cmd.col_v && (q_cmd.bg != NO_COLOR);
        q_mask[SLOT_BG_LO]   = q_cmd.col_v && (q_cmd.bg != NO_COLOR);
    end

    // lowest pending slot
    always_comb begin
        sel = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (mask_reg[i]) sel = 3'(i);
        end
    end

    assign rest = mask_reg & SLOTS'(mask_reg - SLOTS'(1));

    // byte of the selected slot
    always_comb begin
        unique case (sel)
            SLOT_PRE0:  out_byte = cmd_reg.pre0;
            SLOT_PRE1:  out_byte = cmd_reg.pre1;
            SLOT_CTRL:  out_byte = BYTE_COLOR;
            SLOT_FG_HI: out_byte = color_digit(cmd_reg.fg[2:0], 1'b1);
            SLOT_FG_LO: out_byte = color_digit(cmd_reg.fg[2:0], 1'b0);
            SLOT_COMMA: out_byte = BYTE_COMMA;
            SLOT_BG_HI: out_byte = color_digit(cmd_reg.bg[2:0], 1'b1);
            default:    out_byte = color_digit(cmd_reg.bg[2:0], 1'b0);
        endcase
    end

    assign out_valid = (mask_reg != '0);
    assign out_last  = (rest == '0);
    assign fire      = out_valid && out_ready;
    assign q_ready   = !out_valid || (fire && out_last);

    // load a new command or step to the next slot
    always_comb begin
        cmd_next  = cmd_reg;
        mask_next = mask_reg;
        if (q_ready) begin
            mask_next = q_valid ? q_mask : '0;
            if (q_valid) cmd_next = q_cmd;
        end else if (fire) begin
            mask_next = rest;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= '0;
        end else begin
            mask_reg <= mask_next;
        end
    end

    // command payload
    always_ff @(posedge aclk) begin
        cmd_reg <= cmd_next;
    end

endmodule

[sv/ansi_sgr_to_irc_color.sv]
// top level of the ansi sgr to irc colour converter
//
//  channel  dir  tdata           tlast         role
//  s_       in   [7:0] ch        end_of_text   input text bytes
//  m_       out  [7:0] out_byte  last_of_run   converted irc text bytes
//
// an input byte that yields zero or one result keeps the stream at one byte
// per cycle while the output is ready. a colour burst holds the back end
// until its last byte is taken, and the command queue of QUEUE_DEPTH entries
// lets the front keep taking bytes until it fills. synchronous active-low
// reset brings the parser to text mode with both colours unset and empties
// the queue; either side may stall at any time without loss.
module ansi_sgr_to_irc_color #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] ch
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast
);
    import sgr2irc_pkg::*;

    logic fq_valid, fq_ready;
    cmd_t fq_cmd;
    logic qb_valid, qb_ready;
    cmd_t qb_cmd;

    // parser
    sgr2irc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ch    (s_tdata),
        .in_eot   (s_tlast),
        .in_ready (s_tready),
        .q_valid  (fq_valid),
        .q_ready  (fq_ready),
        .q_cmd    (fq_cmd)
    );

    // command queue
    sgr2irc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_cmd    (fq_cmd),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_cmd   (qb_cmd)
    );

    // byte sequencer
    sgr2irc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (qb_valid),
        .q_ready   (qb_ready),
        .q_cmd     (qb_cmd),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_byte  (m_tdata),
        .out_last  (m_tlast)
    );

    // output goes quiet after reset
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // an idle back end always takes a waiting command
    assert property (@(posedge aclk) disable iff (!aresetn)
        (qb_valid && !m_tvalid) |-> qb_ready)
        else $error("back end idle while command waits");

    // a command is only offered with a valid input byte, and is taken exactly when the front accepts that byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        fq_valid |-> (s_tvalid && s_tready == fq_ready))
        else $error("command without accepted input");

    // a non-empty queue output stays until taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        (qb_valid && !qb_ready) |=> qb_valid)
        else $error("queued command lost");

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// self-checking testbench for the ansi sgr to irc color converter
module tb_top;
    import sgr2irc_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 32;
    localparam int PHASE_ITEMS   = 60;
    localparam int REPORT_LIMIT  = 10;

    // irc two-digit codes by colour index
    localparam logic [15:0] IRC_DIGITS [8] = '{"01", "04", "03", "07", "02", "06", "11", "15"};
    // sgr parameter values worth hitting often
    localparam int SGR_CODES [20] = '{0, 30, 31, 32, 33, 34, 35, 36, 37, 39,
                                      40, 41, 42, 43, 44, 45, 46, 47, 49, 38};

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } irc_byte_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;   // [7:0] ch
    logic       s_tlast = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;           // [7:0] out_byte
    logic       m_tlast;

    int idle_pct = 0;
    int stall_pct = 0;
    int items_sent = 0;
    int mismatch_count = 0;
    int cycles = 0;

    // predictor state
    mode_t      seq_mode;
    logic [1:0] par_count;
    logic [6:0] par_value;
    logic       par_done;
    logic [3:0] fg_idx;
    logic [3:0] bg_idx;
    logic [7:0] burst[$];
    irc_byte_t  irc_expected[$];

    ansi_sgr_to_irc_color DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #1 aclk = ~aclk;

    // converter state back to power-up
    function void clear_converter();
        seq_mode  = MODE_TEXT;
        par_count = 2'd0;
        par_value = 7'd0;
        par_done  = 1'b0;
        fg_idx    = NO_COLOR;
        bg_idx    = NO_COLOR;
    endfunction

    // work out the irc bytes caused by one input byte and queue them
    function void convert_byte(input logic [7:0] ch, input logic eot);
        logic        as_text;
        logic [15:0] d;
        irc_byte_t   b;
        burst.delete();
        as_text = 1'b0;
        case (seq_mode)
            MODE_SEQ: begin
                if (ch == BYTE_SEMI || ch == BYTE_M) begin
                    // parameter ends here: apply it
                    if (par_value >= 30 && par_value <= 36) fg_idx = 4'(par_value - 30);
                    if (par_value == 37 || par_value == 39) fg_idx = NO_COLOR;
                    if (par_value >= 41 && par_value <= 47) bg_idx = 4'(par_value - 40);
                    if (par_value == 40 || par_value == 49) bg_idx = NO_COLOR;
                    if (par_value == 0) begin
                        fg_idx = NO_COLOR;
                        bg_idx = NO_COLOR;
                        burst.push_back(BYTE_RESET);
                    end
                    par_count = 2'd0;
                    par_value = 7'd0;
                    par_done  = 1'b0;
                    if (ch == BYTE_M) begin
                        if (fg_idx != NO_COLOR || bg_idx != NO_COLOR)
                            burst.push_back(BYTE_COLOR);
                        if (fg_idx != NO_COLOR) begin
                            d = IRC_DIGITS[fg_idx[2:0]];
                            burst.push_back(d[15:8]);
                            burst.push_back(d[7:0]);
                        end
                        if (bg_idx != NO_COLOR) begin
                            d = IRC_DIGITS[bg_idx[2:0]];
                            burst.push_back(BYTE_COMMA);
                            burst.push_back(d[15:8]);
                            burst.push_back(d[7:0]);
                        end
                        seq_mode = MODE_TEXT;
                    end
                end else if (par_count < 2) begin
                    // only the first two parameter bytes count
                    par_count = par_count + 2'd1;
                    if (!par_done) begin
                        if (ch >= BYTE_ZERO && ch <= BYTE_NINE)
                            par_value = 7'(par_value * 10 + (ch - BYTE_ZERO));
                        else
                            par_done = 1'b1;
                    end
                end
            end
            MODE_ESC: begin
                if (ch == BYTE_LBRACKET) begin
                    seq_mode  = MODE_SEQ;
                    par_count = 2'd0;
                    par_value = 7'd0;
                    par_done  = 1'b0;
                end else begin
                    // lone escape goes out, byte is then plain text
                    burst.push_back(BYTE_ESC);
                    seq_mode = MODE_TEXT;
                    as_text  = 1'b1;
                end
            end
            default: begin
                seq_mode = MODE_TEXT;
                as_text  = 1'b1;
            end
        endcase
        if (as_text) begin
            if (ch == BYTE_ESC)
                seq_mode = MODE_ESC;
            else
                burst.push_back(ch);
        end
        // end of text flushes a pending escape and clears everything
        if (eot) begin
            if (seq_mode == MODE_ESC) burst.push_back(BYTE_ESC);
            clear_converter();
        end
        foreach (burst[i]) begin
            if (i < 6) begin
                b.data = burst[i];
                b.last = (i == burst.size() - 1) || (i == 5);
                irc_expected.push_back(b);
            end
        end
    endfunction

    function void report_error(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) $display("%0t: %s", $realtime, msg);
    endfunction

    // predict on accepted input, check accepted output, drive receiver backpressure
    always @(posedge aclk) begin : scoreboard
        irc_byte_t want;
        if (!aresetn) begin
            clear_converter();
        end else begin
            if (s_tvalid && s_tready) convert_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                if (irc_expected.size() == 0) begin
                    report_error($sformatf("unexpected output byte %02h last %0b",
                                           m_tdata, m_tlast));
                end else begin
                    want = irc_expected.pop_front();
                    if (want.data !== m_tdata || want.last !== m_tlast)
                        report_error($sformatf("expected byte %02h last %0b, got byte %02h last %0b",
                                               want.data, want.last, m_tdata, m_tlast));
                end
            end
        end
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // one input transaction, with random idle cycles ahead of it
    task automatic send_byte(input logic [7:0] ch, input logic eot);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= eot;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic send_text(input string text, input logic eot);
        for (int i = 0; i < text.len(); i++)
            send_byte(text[i], eot && (i == text.len() - 1));
    endtask

    // byte extremes pass straight through
    task automatic test_plain_text();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
    endtask

    // fg and bg set together, then an empty parameter resets both
    task automatic test_color_sequences();
        send_text("\033[31;47m", 1'b0);
        send_text("\033[m", 1'b0);
    endtask

    // lone escape, over-long parameter, parameter starting with a non-digit
    task automatic test_escape_cases();
        send_text("\033A", 1'b0);
        send_text("\033[369m", 1'b0);
        send_text("\033[x5m", 1'b0);
    endtask

    // end of text inside an open sequence and right after an escape
    task automatic test_end_of_text();
        send_text("\033[3", 1'b1);
        send_text("\033", 1'b1);
    endtask

    // mostly well-formed sgr sequences, plus plain text and broken escapes
    task automatic run_random_stream(input int n);
        logic [7:0] seq[$];
        int         start;
        int         kind;
        int         shape;
        int         code;
        logic       broken;
        logic       eot;
        start = items_sent;
        while (items_sent - start < n) begin
            seq.delete();
            kind = $urandom_range(0, 99);
            broken = 1'b0;
            if (kind < 55) begin
                seq.push_back(BYTE_ESC);
                seq.push_back(BYTE_LBRACKET);
                for (int p = 0; p < $urandom_range(1, 3); p++) begin
                    if (p > 0) seq.push_back(BYTE_SEMI);
                    shape = $urandom_range(0, 9);
                    if ($urandom_range(0, 9) < 7)
                        code = SGR_CODES[$urandom_range(0, 19)];
                    else
                        code = $urandom_range(0, 99);
                    if (shape == 1) begin
                        // stray byte ahead of a digit
                        seq.push_back(8'($urandom_range(0, 255)));
                        seq.push_back(8'(BYTE_ZERO + $urandom_range(0, 9)));
                    end else if (shape == 2) begin
                        // digit followed by a stray byte
                        seq.push_back(8'(BYTE_ZERO + $urandom_range(0, 9)));
                        seq.push_back(8'($urandom_range(0, 255)));
                    end else if (shape == 3) begin
                        // three digits, the last is ignored
                        seq.push_back(8'(BYTE_ZERO + code / 10));
                        seq.push_back(8'(BYTE_ZERO + code % 10));
                        seq.push_back(8'(BYTE_ZERO + $urandom_range(0, 9)));
                    end else if (shape != 0) begin
                        if (code >= 10 || $urandom_range(0, 1))
                            seq.push_back(8'(BYTE_ZERO + code / 10));
                        seq.push_back(8'(BYTE_ZERO + code % 10));
                    end
                end
                seq.push_back(BYTE_M);
            end else if (kind < 85) begin
                repeat ($urandom_range(1, 4)) seq.push_back(8'($urandom_range(0, 255)));
            end else begin
                broken = 1'b1;
                seq.push_back(BYTE_ESC);
                if ($urandom_range(0, 1)) begin
                    seq.push_back(BYTE_LBRACKET);
                    repeat ($urandom_range(0, 2))
                        seq.push_back(8'(BYTE_ZERO + $urandom_range(0, 9)));
                end
                if ($urandom_range(0, 1)) seq.push_back(8'($urandom_range(0, 255)));
            end
            foreach (seq[i]) begin
                eot = ($urandom_range(0, 99) < 3) ||
                      (broken && i == seq.size() - 1 && $urandom_range(0, 1));
                send_byte(seq[i], eot);
            end
        end
    endtask

    // random stream under each idling mix
    task automatic test_random_stream();
        idle_pct = 0;  stall_pct = 0;  run_random_stream(PHASE_ITEMS);
        idle_pct = 62; stall_pct = 0;  run_random_stream(PHASE_ITEMS);
        idle_pct = 0;  stall_pct = 62; run_random_stream(PHASE_ITEMS);
        idle_pct = 14; stall_pct = 14; run_random_stream(PHASE_ITEMS);
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_plain_text();
        test_color_sequences();
        test_escape_cases();
        test_end_of_text();
        test_random_stream();
        s_tvalid <= 1'b0;
        stall_pct = 0;
        // let the last prediction land, then drain
        @(posedge aclk);
        while (irc_expected.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
